// ===== rtl/lcdnib_pkg.sv =====
// Package for the character LCD nibble encoder: codes, constants and the init table.
package lcdnib_pkg;

  // Display operation codes carried in the opcode field.
  typedef enum logic [2:0] {
    OP_INIT        = 3'd0,
    OP_PRINT       = 3'd1,
    OP_RAW_CMD     = 3'd2,
    OP_SET_CURSOR  = 3'd3,
    OP_SHIFT_LEFT  = 3'd4,
    OP_SHIFT_RIGHT = 3'd5,
    OP_CLEAR       = 3'd6,
    OP_UNUSED      = 3'd7
  } opcode_t;

  // Largest cursor column; wider columns are clamped to this.
  localparam logic [5:0] MAX_COLUMN = 6'd39;
  // Largest cursor row.
  localparam logic [2:0] MAX_ROW = 3'd3;

  // Controller command bytes.
  localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;

  // Row base addresses in display RAM.
  localparam logic [7:0] ROW1_BASE = 8'h40;
  localparam logic [7:0] ROW2_BASE = 8'h14;
  localparam logic [7:0] ROW3_BASE = 8'h54;

  // Index of the last byte in the run of one operation.
  localparam logic [4:0] INIT_LAST_IDX = 5'd27;
  localparam logic [4:0] CMD_LAST_IDX  = 5'd3;

  // Waits in milliseconds.
  localparam logic [3:0] INIT_WAIT_FIRST  = 4'd15;
  localparam logic [3:0] INIT_WAIT_SECOND = 4'd5;
  localparam logic [3:0] INIT_WAIT_THIRD  = 4'd1;
  localparam logic [2:0] LONG_WAIT_AFTER  = 3'd5;

  // Nibble sequence of the power-on init, one entry per nibble.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0:    nib = 4'h3;
      4'd1:    nib = 4'h3;
      4'd2:    nib = 4'h3;
      4'd3:    nib = 4'h2;
      4'd4:    nib = 4'h2;
      4'd5:    nib = 4'hC;
      4'd6:    nib = 4'h0;
      4'd7:    nib = 4'h8;
      4'd8:    nib = 4'h0;
      4'd9:    nib = 4'h1;
      4'd10:   nib = 4'h0;
      4'd11:   nib = 4'h3;
      4'd12:   nib = 4'h0;
      4'd13:   nib = 4'hC;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_expander_encoder.sv =====
// Top level of the character LCD nibble encoder for an I2C port expander.
//
// Usage: one display operation word enters on the s_ stream (opcode, value_byte,
// column, row). The block answers with a run of expander bytes on the m_ stream,
// one word per cycle while m_tready is high, tlast marking the final byte of the
// run. Each output word also carries the waits in milliseconds that the I2C
// sender must keep before and after the byte. The cfg channel writes the
// backlight bit and is always ready. An init run has 28 bytes, any other run 4
// bytes, and the unused opcode is swallowed with no output. An accepted
// operation is held in the input register; the byte counter walks its run into
// the output register, one byte a cycle while the receiver is ready. The next
// operation is accepted in the cycle in which the last byte of the current run
// is loaded, so runs follow with no gap. When the receiver stalls, the output
// register holds its word and the counter waits; one operation may wait in the
// input register meanwhile. Reset clears all valid flags and the counter and
// sets the backlight bit.
module char_lcd_nibble_expander_encoder (
  input  logic        clk,
  input  logic        rst,
  // Operation words.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode[2:0], value_byte[10:3], column[16:11], row[19:17]
  // Expander byte words.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // expander_byte[7:0], wait_before_ms[11:8], wait_after_ms[14:12]
  output logic        m_tlast,
  // Backlight configuration.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import lcdnib_pkg::*;

  // Input field decode.
  opcode_t    in_op;
  logic [7:0] in_value;
  logic [5:0] in_column;
  logic [2:0] in_row;

  assign in_op     = opcode_t'(s_tdata[2:0]);
  assign in_value  = s_tdata[10:3];
  assign in_column = s_tdata[16:11];
  assign in_row    = s_tdata[19:17];

  // Backlight register.
  logic backlight_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      backlight_on <= cfg_data;
    end
  end

  // Command byte, RS and wait-after of the accepted operation.
  logic [5:0] col_clamped;
  logic [7:0] row_base;
  logic [7:0] cursor_adr;
  logic [7:0] enc_byte;
  logic       enc_rs;
  logic       enc_init;
  logic       enc_live;
  logic [2:0] enc_wa;

  always_comb begin
    col_clamped = (in_column > MAX_COLUMN) ? MAX_COLUMN : in_column;
    case ((in_row > MAX_ROW) ? MAX_ROW : in_row)
      3'd1:    row_base = ROW1_BASE;
      3'd2:    row_base = ROW2_BASE;
      3'd3:    row_base = ROW3_BASE;
      default: row_base = 8'h00;
    endcase
    cursor_adr = {2'b00, col_clamped} + row_base;

    enc_byte = 8'h00;
    enc_rs   = 1'b0;
    enc_init = 1'b0;
    enc_live = 1'b1;
    enc_wa   = 3'd0;
    case (in_op)
      OP_INIT: begin
        enc_init = 1'b1;
        enc_wa   = LONG_WAIT_AFTER;
      end
      OP_PRINT: begin
        enc_byte = in_value;
        enc_rs   = 1'b1;
      end
      OP_RAW_CMD:     enc_byte = in_value;
      OP_SET_CURSOR:  enc_byte = CMD_SET_DDRAM | cursor_adr;
      OP_SHIFT_LEFT:  enc_byte = CMD_SHIFT_LEFT;
      OP_SHIFT_RIGHT: enc_byte = CMD_SHIFT_RIGHT;
      OP_CLEAR: begin
        enc_byte = CMD_CLEAR;
        enc_wa   = LONG_WAIT_AFTER;
      end
      default:        enc_live = 1'b0;
    endcase
  end

  // Input register and byte counter.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_rs;
  logic       hold_init;
  logic [2:0] hold_wa;
  logic [4:0] idx;
  logic [4:0] last_idx;
  logic       is_last;
  logic       load;
  logic       in_accept;

  assign last_idx  = hold_init ? INIT_LAST_IDX : CMD_LAST_IDX;
  assign is_last   = (idx == last_idx);
  assign load      = hold_valid && (!m_tvalid || m_tready);
  assign s_tready  = !hold_valid || (load && is_last);
  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= 5'd0;
    end else begin
      if (in_accept) begin
        hold_valid <= enc_live;
        idx        <= 5'd0;
      end else if (load) begin
        if (is_last) begin
          hold_valid <= 1'b0;
          idx        <= 5'd0;
        end else begin
          idx <= idx + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_byte <= enc_byte;
      hold_rs   <= enc_rs;
      hold_init <= enc_init;
      hold_wa   <= enc_wa;
    end
  end

  // Expander byte for the current counter position.
  logic [3:0] nib_idx;
  logic       strobe;
  logic [3:0] nib;
  logic [3:0] wb;

  always_comb begin
    nib_idx = idx[4:1];
    strobe  = !idx[0];
    if (hold_init) begin
      nib = init_nibble(nib_idx);
    end else begin
      nib = idx[1] ? hold_byte[3:0] : hold_byte[7:4];
    end
    wb = 4'd0;
    if (hold_init && strobe) begin
      case (nib_idx)
        4'd0:    wb = INIT_WAIT_FIRST;
        4'd1:    wb = INIT_WAIT_SECOND;
        4'd2:    wb = INIT_WAIT_THIRD;
        default: wb = 4'd0;
      endcase
    end
  end

  // Output register.
  logic [7:0] out_byte;
  logic [3:0] out_wb;
  logic [2:0] out_wa;
  logic       out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= {nib, backlight_on, strobe, 1'b0, hold_rs};
      out_wb   <= wb;
      out_wa   <= hold_wa;
      out_last <= is_last;
    end
  end

  assign m_tdata = {1'b0, out_wa, out_wb, out_byte};
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  // The counter never runs past the end of the run it walks.
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (idx <= last_idx))
    else $error("byte counter beyond end of run");

  // A wait before a byte only ever comes with E high.
  a_wait_on_strobe: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[11:8] != 4'd0)) |-> m_tdata[2])
    else $error("wait before on a byte with E low");

  // A run always ends on the falling half of a nibble.
  a_last_strobe_low: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tdata[2])
    else $error("run ends with E high");

  // RW stays low in every emitted byte.
  a_rw_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[1])
    else $error("RW bit set in expander byte");
`endif

endmodule

// ===== tb/tb_char_lcd_nibble_expander_encoder.sv =====
// Self-checking testbench for the character LCD nibble encoder, with stream driver and monitor.
module tb_char_lcd_nibble_expander_encoder;
  import lcdnib_pkg::*;

  // One expected expander word, as it should appear on the master stream.
  typedef struct packed {
    logic [7:0] xbyte;
    logic [3:0] pre_ms;
    logic [2:0] post_ms;
    logic       tail;
  } lcd_word_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // opcode[2:0], value_byte[10:3], column[16:11], row[19:17]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // expander_byte[7:0], wait_before_ms[11:8], wait_after_ms[14:12]
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // Operation words still to be offered, and expander words still owed by the block.
  logic [23:0] op_backlog[$];
  lcd_word_t   lcd_bytes_due[$];

  // Our own copy of the backlight register.
  logic        backlight_shadow = 1'b1;
  int          mismatches = 0;
  int          src_idle_pct = 28;
  int          snk_idle_pct = 28;
  int          quiet_cycles = 0;

  // Power-on nibble sequence sent by the init operation.
  logic [3:0]  power_on_nibbles [14] = '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'hC, 4'h0,
                                         4'h8, 4'h0, 4'h1, 4'h0, 4'h3, 4'h0, 4'hC};

  char_lcd_nibble_expander_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // One nibble leaves as two words: strobe high, then strobe low.
  function automatic void owe_nibble(input logic [3:0] nib, input logic rs,
                                     input logic [3:0] pre, input logic [2:0] post);
    lcd_word_t w;
    w.xbyte   = {nib, backlight_shadow, 1'b1, 1'b0, rs};
    w.pre_ms  = pre;
    w.post_ms = post;
    w.tail    = 1'b0;
    lcd_bytes_due.push_back(w);
    w.xbyte[2] = 1'b0;
    w.pre_ms   = 4'd0;
    lcd_bytes_due.push_back(w);
  endfunction

  // A full byte goes high nibble first.
  function automatic void owe_display_byte(input logic [7:0] b, input logic rs,
                                           input logic [2:0] post);
    owe_nibble(b[7:4], rs, 4'd0, post);
    owe_nibble(b[3:0], rs, 4'd0, post);
  endfunction

  // Works out the expander words that one operation word should produce.
  function automatic void expand_operation(input logic [23:0] word);
    opcode_t    op;
    logic [7:0] value;
    logic [5:0] col;
    logic [2:0] row;
    logic [7:0] addr;
    logic [3:0] pre;
    lcd_word_t  w;
    int         depth;
    op    = opcode_t'(word[2:0]);
    value = word[10:3];
    col   = word[16:11];
    row   = word[19:17];
    depth = lcd_bytes_due.size();
    case (op)
      OP_INIT: begin
        for (int i = 0; i < 14; i++) begin
          pre = (i == 0) ? INIT_WAIT_FIRST : (i == 1) ? INIT_WAIT_SECOND :
                (i == 2) ? INIT_WAIT_THIRD : 4'd0;
          owe_nibble(power_on_nibbles[i], 1'b0, pre, LONG_WAIT_AFTER);
        end
      end
      OP_PRINT:       owe_display_byte(value, 1'b1, 3'd0);
      OP_RAW_CMD:     owe_display_byte(value, 1'b0, 3'd0);
      OP_SET_CURSOR: begin
        if (col > MAX_COLUMN) col = MAX_COLUMN;
        if (row > MAX_ROW) row = MAX_ROW;
        addr = {2'b00, col};
        case (row)
          3'd1:    addr = addr + ROW1_BASE;
          3'd2:    addr = addr + ROW2_BASE;
          3'd3:    addr = addr + ROW3_BASE;
          default: addr = addr;
        endcase
        owe_display_byte(CMD_SET_DDRAM | addr, 1'b0, 3'd0);
      end
      OP_SHIFT_LEFT:  owe_display_byte(CMD_SHIFT_LEFT, 1'b0, 3'd0);
      OP_SHIFT_RIGHT: owe_display_byte(CMD_SHIFT_RIGHT, 1'b0, 3'd0);
      OP_CLEAR:       owe_display_byte(CMD_CLEAR, 1'b0, LONG_WAIT_AFTER);
      default: ;
    endcase
    // The final word of a run carries tlast.
    if (lcd_bytes_due.size() > depth) begin
      w = lcd_bytes_due.pop_back();
      w.tail = 1'b1;
      lcd_bytes_due.push_back(w);
    end
  endfunction

  function automatic logic [23:0] pack_operation(input opcode_t op, input logic [7:0] value,
                                                 input logic [5:0] col, input logic [2:0] row);
    return {4'b0000, row, col, value, op};
  endfunction

  // Random operation: mostly short commands, a few inits and unused codes.
  function automatic logic [23:0] random_operation();
    int         pick;
    opcode_t    op;
    logic [5:0] col;
    pick = $urandom_range(99);
    if (pick < 5) op = OP_INIT;
    else if (pick < 10) op = OP_UNUSED;
    else op = opcode_t'($urandom_range(OP_PRINT, OP_CLEAR));
    // Columns cluster around the clamp point now and then.
    if ($urandom_range(4) == 0) col = 6'($urandom_range(MAX_COLUMN + 2, MAX_COLUMN - 1));
    else col = 6'($urandom_range(63));
    return pack_operation(op, 8'($urandom_range(255)), col, 3'($urandom_range(7)));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: %s got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Waits until every operation has been taken and every word has come back.
  // The check is made at the falling edge, once the rising-edge updates have settled.
  task automatic wait_until_quiet();
    do @(negedge clk);
    while (op_backlog.size() != 0 || s_tvalid || lcd_bytes_due.size() != 0);
  endtask

  // Writes the backlight bit while the block has nothing in flight.
  task automatic write_backlight(input logic on);
    wait_until_quiet();
    // An unused opcode may still be in the block without owing a word.
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= on;
    do @(posedge clk); while (!cfg_ready);
    backlight_shadow = on;
    cfg_valid <= 1'b0;
  endtask

  // Driver: offers the next operation word once the current one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expand_operation(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= op_backlog.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted expander word against the oldest one owed.
  always @(posedge clk) begin
    lcd_word_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (lcd_bytes_due.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, 0);
        end else begin
          w = lcd_bytes_due.pop_front();
          if (m_tdata[7:0] !== w.xbyte) report_mismatch("expander_byte", m_tdata[7:0], w.xbyte);
          if (m_tdata[11:8] !== w.pre_ms)
            report_mismatch("wait_before_ms", m_tdata[11:8], w.pre_ms);
          if (m_tdata[14:12] !== w.post_ms)
            report_mismatch("wait_after_ms", m_tdata[14:12], w.post_ms);
          if (m_tlast !== w.tail) report_mismatch("last", m_tlast, w.tail);
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: gives up after a long run of cycles with no word moving anywhere.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_nibble_expander_encoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed operations, then random phases under several backlight settings.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation, field extremes, clamping and the unused opcode.
    op_backlog.push_back(pack_operation(OP_INIT, 8'h00, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_PRINT, 8'h00, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_PRINT, 8'hFF, 6'd63, 3'd7));
    op_backlog.push_back(pack_operation(OP_PRINT, 8'hA5, 6'd21, 3'd2));
    op_backlog.push_back(pack_operation(OP_RAW_CMD, 8'h00, 6'd63, 3'd7));
    op_backlog.push_back(pack_operation(OP_RAW_CMD, 8'hFF, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_RAW_CMD, 8'h5A, 6'd5, 3'd1));
    op_backlog.push_back(pack_operation(OP_SET_CURSOR, 8'hFF, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_SET_CURSOR, 8'h00, MAX_COLUMN, 3'd1));
    op_backlog.push_back(pack_operation(OP_SET_CURSOR, 8'h00, MAX_COLUMN + 6'd1, 3'd2));
    op_backlog.push_back(pack_operation(OP_SET_CURSOR, 8'h00, 6'd63, 3'd3));
    op_backlog.push_back(pack_operation(OP_SET_CURSOR, 8'h00, 6'd63, 3'd7));
    op_backlog.push_back(pack_operation(OP_SET_CURSOR, 8'h00, 6'd17, 3'd4));
    op_backlog.push_back(pack_operation(OP_SHIFT_LEFT, 8'hFF, 6'd63, 3'd7));
    op_backlog.push_back(pack_operation(OP_SHIFT_RIGHT, 8'h00, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_CLEAR, 8'hFF, 6'd63, 3'd7));
    op_backlog.push_back(pack_operation(OP_UNUSED, 8'hFF, 6'd63, 3'd7));
    op_backlog.push_back(pack_operation(OP_PRINT, 8'h3C, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_UNUSED, 8'h00, 6'd0, 3'd0));
    op_backlog.push_back(pack_operation(OP_INIT, 8'hFF, 6'd63, 3'd7));

    // Backlight off, both sides idling.
    write_backlight(1'b0);
    repeat (120) op_backlog.push_back(random_operation());

    // Backlight on, a long stretch with no idling at all.
    write_backlight(1'b1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (110) op_backlog.push_back(random_operation());

    // Backlight off again, idling resumed.
    write_backlight(1'b0);
    src_idle_pct = 28;
    snk_idle_pct = 28;
    repeat (110) op_backlog.push_back(random_operation());

    wait_until_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("char_lcd_nibble_expander_encoder: match");
    end else begin
      $display("char_lcd_nibble_expander_encoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcdnib_pkg.sv
rtl/char_lcd_nibble_expander_encoder.sv
tb/tb_char_lcd_nibble_expander_encoder.sv
